[src/itoa_pkg.sv]
// Package for the integer-to-ASCII formatter: conversion kind codes, sign codes,
// character codes, controller/datapath command and status structs, digit helper.
// No dependencies.
package itoa_pkg;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_HEXU = 3'd4;
    localparam logic [2:0] OP_PTR  = 3'd5;

    localparam logic [6:0] CH_NUL   = 7'h00;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LA    = 7'h61;
    localparam logic [6:0] CH_UA    = 7'h41;
    localparam logic [6:0] CH_LX    = 7'h78;
    localparam logic [6:0] CH_UX    = 7'h58;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_SPACE = 7'h20;

    typedef enum logic [1:0] {
        SGN_NONE,
        SGN_MINUS,
        SGN_PLUS,
        SGN_SPACE
    } sign_t;

    typedef struct packed {
        logic load;   // capture the input transaction
        logic dab;    // one double-dabble step
        logic norm;   // drop one leading zero digit
        logic zload;  // load pad count and string length
        logic emit;   // push the next character into the output register
    } itoa_cmd_t;

    typedef struct packed {
        logic op_bad;     // offered kind code is unused
        logic is_dec;     // offered kind is decimal
        logic cnt_one;    // last conversion step
        logic lead_zero;  // top digit is a leading zero
        logic out_free;   // output register can take a character
        logic fin;        // the next character is the final one
    } itoa_sts_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {3'b000, d};
        end
        else
        begin
            c = (upper ? CH_UA : CH_LA) + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

[src/itoa_if.sv]
// Handshake interfaces for the formatter: input item channel and character channel.
// Valid/ready handshake; no package dependency.
interface itoa_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] value;
    logic        precision_given;
    logic [5:0]  precision;
    logic        plus_flag;
    logic        space_flag;
    logic        alt_flag;

    modport source (output valid, op, value, precision_given, precision, plus_flag,
                    space_flag, alt_flag, input ready);
    modport sink   (input valid, op, value, precision_given, precision, plus_flag,
                    space_flag, alt_flag, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;
    logic       empty_string;

    modport source (output valid, char_code, last_char, empty_string, input ready);
    modport sink   (input valid, char_code, last_char, empty_string, output ready);
endinterface

[src/itoa_ctrl.sv]
// Controller of the formatter: sequences capture, conversion, normalisation and emission.
// Depends on itoa_pkg.
module itoa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itoa_pkg::itoa_sts_t sts,
    output itoa_pkg::itoa_cmd_t cmd
);
    import itoa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_NORM = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !sts.op_bad)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.is_dec ? ST_CONV : ST_NORM;
                end
            end
            ST_CONV:
            begin
                cmd.dab = 1'b1;
                if (sts.cnt_one)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (sts.lead_zero)
                begin
                    cmd.norm = 1'b1;
                end
                else
                begin
                    cmd.zload  = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.fin)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/itoa_dpath.sv]
// Datapath of the formatter: digit register, double-dabble converter, pad and
// length counters, character selection and output register. Depends on itoa_pkg, itoa_if.
module itoa_dpath #(
    parameter int VALUE_WIDTH   = 64,
    parameter int MAX_PRECISION = 40
) (
    input  logic                clk,
    input  logic                rst_n,
    itoa_in_if.sink             item,
    itoa_out_if.source          chars,
    input  itoa_pkg::itoa_cmd_t cmd,
    output itoa_pkg::itoa_sts_t sts
);
    import itoa_pkg::*;

    localparam int NDIG = (VALUE_WIDTH + 2) / 3;
    localparam int NHEX = (VALUE_WIDTH + 3) / 4;
    localparam int NW   = $clog2(NDIG + 1);
    localparam int CMAX = (VALUE_WIDTH > MAX_PRECISION) ? VALUE_WIDTH : MAX_PRECISION;
    localparam int CW   = $clog2(CMAX + 1);
    localparam int RW   = $clog2(MAX_PRECISION + NDIG + 4);
    localparam logic [5:0] MAXP = 6'(MAX_PRECISION);

    logic [NDIG-1:0][3:0]   digs_reg;
    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [NW-1:0]          nd_reg;
    logic [CW-1:0]          cnt_reg;
    logic [RW-1:0]          rem_reg;
    logic [5:0]             prec_reg;
    sign_t                  sign_reg;
    logic                   octalt_reg;
    logic                   oct0_reg;
    logic                   hx0_reg;
    logic                   hxx_reg;
    logic                   upper_reg;
    logic                   ovalid_reg;
    logic                   ovalid_next;
    logic [6:0]             char_reg;
    logic                   last_reg;
    logic                   empty_reg;

    // input decode
    logic [VALUE_WIDTH-1:0] vw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic                   is_dec;
    logic                   hexpre;
    logic [5:0]             prec_in;
    sign_t                  sign_in;
    logic [3*NDIG-1:0]      oct_ext;
    logic [4*NHEX-1:0]      hex_ext;
    logic [NDIG-1:0][3:0]   digs_load;

    always_comb
    begin
        vw      = item.value[VALUE_WIDTH-1:0];
        neg     = (item.op == OP_SDEC) && vw[VALUE_WIDTH-1];
        mag     = neg ? (~vw + 1'b1) : vw;
        is_dec  = (item.op == OP_SDEC) || (item.op == OP_UDEC);
        hexpre  = (((item.op == OP_HEXL) || (item.op == OP_HEXU)) && item.alt_flag
                   && (vw != '0)) || (item.op == OP_PTR);
        if (!item.precision_given)
        begin
            prec_in = 6'd1;
        end
        else
        begin
            prec_in = (item.precision > MAXP) ? MAXP : item.precision;
        end
        if (neg)
        begin
            sign_in = SGN_MINUS;
        end
        else if ((item.op == OP_SDEC) && item.plus_flag)
        begin
            sign_in = SGN_PLUS;
        end
        else if ((item.op == OP_SDEC) && item.space_flag)
        begin
            sign_in = SGN_SPACE;
        end
        else
        begin
            sign_in = SGN_NONE;
        end
        oct_ext   = (3*NDIG)'(mag);
        hex_ext   = (4*NHEX)'(mag);
        digs_load = '0;
        if (item.op == OP_OCT)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                digs_load[i] = {1'b0, oct_ext[3*i +: 3]};
            end
        end
        else if (!is_dec)
        begin
            for (int i = 0; i < NHEX; i++)
            begin
                digs_load[i] = hex_ext[4*i +: 4];
            end
        end
    end

    // double-dabble step: adjust every BCD digit, then shift in the next bit
    logic [NDIG-1:0][3:0] adj;
    logic [4*NDIG-1:0]    adj_flat;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[i] = (digs_reg[i] >= 4'd5) ? (digs_reg[i] + 4'd3) : digs_reg[i];
        end
        adj_flat = adj;
    end

    // pad count and total string length
    logic [RW-1:0] prec_w;
    logic [RW-1:0] nd_w;
    logic [RW-1:0] pad_w;
    logic          oct0_calc;
    logic [RW-1:0] len_w;

    always_comb
    begin
        prec_w    = RW'(prec_reg);
        nd_w      = RW'(nd_reg);
        pad_w     = (prec_w > nd_w) ? (prec_w - nd_w) : '0;
        oct0_calc = octalt_reg && (prec_w <= nd_w);
        len_w     = RW'(sign_reg != SGN_NONE) + RW'(oct0_calc)
                  + (hx0_reg ? RW'(2) : '0) + pad_w + nd_w;
    end

    // next character, by priority: sign, octal zero, hex prefix, pad, digits
    logic [6:0] char_sel;
    logic       empty_sel;

    always_comb
    begin
        empty_sel = 1'b0;
        if (rem_reg == '0)
        begin
            char_sel  = CH_NUL;
            empty_sel = 1'b1;
        end
        else if (sign_reg != SGN_NONE)
        begin
            case (sign_reg)
                SGN_MINUS: char_sel = CH_MINUS;
                SGN_PLUS:  char_sel = CH_PLUS;
                default:   char_sel = CH_SPACE;
            endcase
        end
        else if (oct0_reg || hx0_reg)
        begin
            char_sel = CH_ZERO;
        end
        else if (hxx_reg)
        begin
            char_sel = upper_reg ? CH_UX : CH_LX;
        end
        else if (cnt_reg != '0)
        begin
            char_sel = CH_ZERO;
        end
        else
        begin
            char_sel = digit_char(digs_reg[NDIG-1], upper_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            digs_reg   <= digs_load;
            bin_reg    <= mag;
            nd_reg     <= NW'(NDIG);
            cnt_reg    <= CW'(VALUE_WIDTH);
            prec_reg   <= prec_in;
            sign_reg   <= sign_in;
            octalt_reg <= (item.op == OP_OCT) && item.alt_flag;
            oct0_reg   <= 1'b0;
            hx0_reg    <= hexpre;
            hxx_reg    <= hexpre;
            upper_reg  <= (item.op == OP_HEXU);
        end
        else if (cmd.dab)
        begin
            digs_reg <= {adj_flat[4*NDIG-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_reg  <= {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_reg  <= cnt_reg - 1'b1;
        end
        else if (cmd.norm)
        begin
            digs_reg <= {digs_reg[NDIG-2:0], 4'h0};
            nd_reg   <= nd_reg - 1'b1;
        end
        else if (cmd.zload)
        begin
            cnt_reg  <= CW'(pad_w);
            oct0_reg <= oct0_calc;
            rem_reg  <= len_w;
        end
        else if (cmd.emit)
        begin
            char_reg  <= char_sel;
            last_reg  <= (rem_reg <= RW'(1));
            empty_reg <= empty_sel;
            if (rem_reg != '0)
            begin
                rem_reg <= rem_reg - 1'b1;
            end
            // retire the element just sent
            if (rem_reg == '0)
            begin
                rem_reg <= '0;
            end
            else if (sign_reg != SGN_NONE)
            begin
                sign_reg <= SGN_NONE;
            end
            else if (oct0_reg)
            begin
                oct0_reg <= 1'b0;
            end
            else if (hx0_reg)
            begin
                hx0_reg <= 1'b0;
            end
            else if (hxx_reg)
            begin
                hxx_reg <= 1'b0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                digs_reg <= {digs_reg[NDIG-2:0], 4'h0};
                nd_reg   <= nd_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (chars.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    assign chars.valid        = ovalid_reg;
    assign chars.char_code    = char_reg;
    assign chars.last_char    = last_reg;
    assign chars.empty_string = empty_reg;

    assign sts.op_bad    = (item.op > OP_PTR);
    assign sts.is_dec    = is_dec;
    assign sts.cnt_one   = (cnt_reg == CW'(1));
    assign sts.lead_zero = (nd_reg != '0) && (digs_reg[NDIG-1] == 4'h0);
    assign sts.out_free  = !ovalid_reg || chars.ready;
    assign sts.fin       = (rem_reg <= RW'(1));

endmodule

[src/integer_to_ascii_formatter_unit.sv]
// Top level of the integer-to-ASCII formatter: controller plus datapath.
// Depends on itoa_pkg, itoa_if, itoa_ctrl, itoa_dpath.
//
// Usage
//   item  : one transaction carries a 64-bit value, a conversion kind (signed or
//           unsigned decimal, octal, lower or upper hex, pointer) and the printf
//           flags. Unused kind codes are taken and dropped without output.
//   chars : one transaction per ASCII character, last_char marking the end of
//           the string; an empty string is a single transaction with
//           empty_string and last_char set and char_code zero.
//   item.ready is high only while no item is in work; one item at a time.
//   Processing: decimal kinds first pass through the double-dabble converter,
//   then every kind drops leading zero digits, sizes the string and emits its
//   characters in order.
//   Reset clears the controller and the output valid; the datapath holds no
//   state between items.
//   A stalled chars receiver holds the character in the output register and
//   freezes emission; the next item is taken while the final character waits.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_WIDTH   = 64,
    parameter int MAX_PRECISION = 40
) (
    input  logic       clk,
    input  logic       rst_n,
    itoa_in_if.sink    item,
    itoa_out_if.source chars
);
    import itoa_pkg::*;

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    // controller: sequencing only, drives the input handshake
    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: digit conversion, character selection and output register
    itoa_dpath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .chars (chars),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

[src/itoa_checker.sv]
// Port-level checker for the formatter, bound to the top level.
// Depends on itoa_pkg and integer_to_ascii_formatter_unit.
module itoa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] in_op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_char,
    input logic       out_last,
    input logic       out_empty
);
    import itoa_pkg::*;

    // hold a stalled character
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char)
            && $stable(out_last) && $stable(out_empty)))
        else $error("stalled character changed");

    // an empty string is a single null final transaction
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_empty) |-> (out_last && (out_char == CH_NUL)))
        else $error("malformed empty string");

    // no new item while a string is still incomplete
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> !in_ready)
        else $error("input ready in the middle of a string");

    // a valid kind blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_op <= OP_PTR)) |=> !in_ready)
        else $error("input ready right after a valid item");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_op     (item.op),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_char  (chars.char_code),
    .out_last  (chars.last_char),
    .out_empty (chars.empty_string)
);

[tb/tb.sv]
// Self-checking testbench for integer_to_ascii_formatter_unit (printf %d %u %o %x %X %p).
// Depends on itoa_pkg and the itoa_in_if / itoa_out_if interfaces from the RTL sources.
// Directed table first, then random items under four idling phases plus one long sink hold.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    localparam int VALUE_BITS       = 64;
    localparam int MAX_PREC         = 40;
    localparam int RANDOM_PER_PHASE = 97;
    localparam int HOLD_OFF_CYCLES  = 600;
    localparam int TAIL_CYCLES      = 250;
    localparam int QUIET_LIMIT      = 5000;

    // Kind codes the block must swallow without producing any character
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] value;
        logic        precision_given;
        logic [5:0]  precision;
        logic        plus_flag;
        logic        space_flag;
        logic        alt_flag;
    } fmt_item_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
        logic       empty_string;
    } char_beat_t;

    // How a directed row gets its expectation: typed string, predictor, or nothing at all
    typedef enum {
        ROW_TEXT,
        ROW_MODEL,
        ROW_NONE
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        fmt_item_t item;
        string     want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    itoa_in_if  item_if ();
    itoa_out_if chars_if ();

    integer_to_ascii_formatter_unit #(
        .VALUE_WIDTH   (VALUE_BITS),
        .MAX_PRECISION (MAX_PREC)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .chars (chars_if)
    );

    // Characters still owed by the block, oldest first
    char_beat_t pending_chars[$];

    int error_count    = 0;
    int items_accepted = 0;
    int items_ignored  = 0;
    int chars_checked  = 0;
    int empty_strings  = 0;

    // Idling knobs, changed by the stimulus process between phases
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    // Raised once by the stimulus process; the character sink consumes it and holds off
    bit  hold_off_req   = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Predict the character string for one item. Zero counts as no digits here, so the
    // precision padding produces the single '0' when no precision was stated.
    function automatic void format_item(input fmt_item_t it);
        logic [63:0] mag;
        logic [63:0] base;
        logic [63:0] d;
        logic [6:0]  digits[$];
        logic [6:0]  text[$];
        int unsigned prec;
        int unsigned zeros;
        if (it.op > OP_PTR)
        begin
            return;
        end
        if (it.precision_given)
        begin
            prec = (it.precision > MAX_PREC) ? MAX_PREC : it.precision;
        end
        else
        begin
            prec = 1;
        end
        mag = it.value;
        if (it.op == OP_SDEC)
        begin
            // Sign handling: minus wins, then plus, then space
            if (it.value[VALUE_BITS-1])
            begin
                text.push_back(CH_MINUS);
                mag = ~it.value + 64'd1;
            end
            else if (it.plus_flag)
            begin
                text.push_back(CH_PLUS);
            end
            else if (it.space_flag)
            begin
                text.push_back(CH_SPACE);
            end
        end
        if (it.op == OP_SDEC || it.op == OP_UDEC)
        begin
            base = 64'd10;
        end
        else if (it.op == OP_OCT)
        begin
            base = 64'd8;
        end
        else
        begin
            base = 64'd16;
        end
        while (mag != 64'd0)
        begin
            d = mag % base;
            if (d < 64'd10)
            begin
                digits.push_front(CH_ZERO + d[6:0]);
            end
            else
            begin
                digits.push_front(((it.op == OP_HEXU) ? CH_UA : CH_LA) + d[6:0] - 7'd10);
            end
            mag = mag / base;
        end
        zeros = (prec > digits.size()) ? prec - digits.size() : 0;
        // Octal alternate form only adds a zero when the digits do not start with one
        if (it.op == OP_OCT && it.alt_flag && zeros == 0)
        begin
            text.push_back(CH_ZERO);
        end
        // Hex prefix for non-zero values; pointer always carries a lower-case prefix
        if (((it.op == OP_HEXL || it.op == OP_HEXU) && it.alt_flag && it.value != 64'd0)
            || it.op == OP_PTR)
        begin
            text.push_back(CH_ZERO);
            text.push_back((it.op == OP_HEXU) ? CH_UX : CH_LX);
        end
        repeat (zeros)
        begin
            text.push_back(CH_ZERO);
        end
        foreach (digits[i])
        begin
            text.push_back(digits[i]);
        end
        if (text.size() == 0)
        begin
            pending_chars.push_back('{char_code: CH_NUL, last_char: 1'b1, empty_string: 1'b1});
        end
        else
        begin
            foreach (text[i])
            begin
                pending_chars.push_back('{char_code: text[i],
                                          last_char: (i == text.size() - 1),
                                          empty_string: 1'b0});
            end
        end
    endfunction

    // Queue a string typed straight into the table; an empty string is one empty beat
    function automatic void queue_text(input string s);
        if (s.len() == 0)
        begin
            pending_chars.push_back('{char_code: CH_NUL, last_char: 1'b1, empty_string: 1'b1});
        end
        else
        begin
            for (int i = 0; i < s.len(); i++)
            begin
                pending_chars.push_back('{char_code: 7'(s[i]),
                                          last_char: (i == s.len() - 1),
                                          empty_string: 1'b0});
            end
        end
    endfunction

    function automatic stim_row_t mk_row(input row_kind_t kind, input logic [2:0] op,
                                         input logic [63:0] value, input logic pg,
                                         input logic [5:0] prec, input logic plus,
                                         input logic space, input logic alt,
                                         input string want);
        stim_row_t r;
        r.kind = kind;
        r.item = '{op: op, value: value, precision_given: pg, precision: prec,
                   plus_flag: plus, space_flag: space, alt_flag: alt};
        r.want = want;
        return r;
    endfunction

    // Random values lean towards the corners: zero, the sign boundary, short and long digit
    // strings, single set bits.
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = {$urandom(), $urandom()};
            1: v = 64'($urandom_range(0, 20));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 64'd0;
                    1: v = '1;
                    2: v = 64'h8000_0000_0000_0000;
                    default: v = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            3: v = 64'd0 - 64'($urandom_range(1, 1000));
            4: v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
            5: v = 64'd1 << $urandom_range(0, 63);
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    function automatic fmt_item_t rand_item();
        fmt_item_t it;
        // Now and then offer an unused kind code, which the block must drop
        if ($urandom_range(0, 19) == 0)
        begin
            it.op = 3'($urandom_range(6, 7));
        end
        else
        begin
            it.op = 3'($urandom_range(0, 5));
        end
        it.value           = rand_value();
        it.precision_given = 1'($urandom_range(0, 1));
        // Mostly short precisions; a fifth go all the way, past the saturation point
        if ($urandom_range(0, 4) == 0)
        begin
            it.precision = 6'($urandom_range(0, 63));
        end
        else
        begin
            it.precision = 6'($urandom_range(0, 9));
        end
        it.plus_flag  = 1'($urandom_range(0, 1));
        it.space_flag = 1'($urandom_range(0, 1));
        it.alt_flag   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Offer one item and hold it until the block takes it. Returns in the step of the
    // accepting edge, without touching valid, so a back-to-back item keeps valid high.
    task automatic send_item(input fmt_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid           <= 1'b1;
        item_if.op              <= it.op;
        item_if.value           <= it.value;
        item_if.precision_given <= it.precision_given;
        item_if.precision       <= it.precision;
        item_if.plus_flag       <= it.plus_flag;
        item_if.space_flag      <= it.space_flag;
        item_if.alt_flag        <= it.alt_flag;
        @(posedge clk);
        while (!item_if.ready)
        begin
            @(posedge clk);
        end
        items_accepted++;
        if (it.op > OP_PTR)
        begin
            items_ignored++;
        end
    endtask

    // Stimulus: reset, directed table, then four idling phases of random items
    initial
    begin : stimulus
        stim_row_t directed_rows[$];
        fmt_item_t it;
        int        counted;

        rst_n                   <= 1'b0;
        item_if.valid           <= 1'b0;
        item_if.op              <= OP_SDEC;
        item_if.value           <= '0;
        item_if.precision_given <= 1'b0;
        item_if.precision       <= '0;
        item_if.plus_flag       <= 1'b0;
        item_if.space_flag      <= 1'b0;
        item_if.alt_flag        <= 1'b0;

        repeat (9)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        // Signed decimal: zero with and without precision, sign kept on an empty zero,
        // both ends of the signed range, flag precedence, saturated precision
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, 64'd0, 0, 0, 0, 0, 0, "0"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, 64'd0, 1, 0, 0, 0, 0, ""));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, 64'd0, 1, 0, 1, 0, 0, "+"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, 64'd0, 1, 0, 0, 1, 0, " "));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, 64'h8000_0000_0000_0000,
                                       0, 0, 0, 0, 0, "-9223372036854775808"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF,
                                       0, 0, 1, 0, 0, "+9223372036854775807"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, '1, 0, 0, 0, 1, 0, "-1"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_SDEC, 64'd42, 0, 0, 1, 1, 0, "+42"));
        directed_rows.push_back(mk_row(ROW_MODEL, OP_SDEC, 64'h8000_0000_0000_0000,
                                       1, 40, 0, 0, 0, ""));
        directed_rows.push_back(mk_row(ROW_MODEL, OP_SDEC, 64'd5, 1, 63, 1, 0, 0, ""));
        // Unsigned decimal ignores every flag
        directed_rows.push_back(mk_row(ROW_TEXT, OP_UDEC, '1, 0, 0, 1, 1, 1,
                                       "18446744073709551615"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_UDEC, 64'd0, 1, 0, 1, 0, 0, ""));
        // Octal: alternate zero only when the digits do not already lead with one
        directed_rows.push_back(mk_row(ROW_MODEL, OP_OCT, '1, 0, 0, 0, 0, 1, ""));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_OCT, 64'd0, 1, 0, 0, 0, 1, "0"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_OCT, 64'd0, 1, 0, 0, 0, 0, ""));
        directed_rows.push_back(mk_row(ROW_MODEL, OP_OCT, 64'd8, 1, 5, 0, 0, 1, ""));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_OCT, 64'd8, 0, 0, 0, 0, 1, "010"));
        // Hex: prefix only for non-zero values, case follows the kind
        directed_rows.push_back(mk_row(ROW_TEXT, OP_HEXL, '1, 0, 0, 0, 0, 1,
                                       "0xffffffffffffffff"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_HEXU, 64'hDEAD_BEEF, 0, 0, 0, 0, 1,
                                       "0XDEADBEEF"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_HEXL, 64'd0, 0, 0, 0, 0, 1, "0"));
        directed_rows.push_back(mk_row(ROW_MODEL, OP_HEXU, 64'hABC, 1, 63, 0, 0, 1, ""));
        // Pointer: prefix always, even on an empty zero
        directed_rows.push_back(mk_row(ROW_TEXT, OP_PTR, 64'd0, 1, 0, 0, 0, 0, "0x"));
        directed_rows.push_back(mk_row(ROW_TEXT, OP_PTR, 64'h1234_ABCD, 0, 0, 0, 0, 0,
                                       "0x1234abcd"));
        // Unused kind codes are taken and dropped
        directed_rows.push_back(mk_row(ROW_NONE, OP_UNUSED_6, 64'd7, 0, 0, 0, 0, 0, ""));
        directed_rows.push_back(mk_row(ROW_NONE, OP_UNUSED_7, '1, 1, 63, 1, 1, 1, ""));

        foreach (directed_rows[r])
        begin
            send_item(directed_rows[r].item);
            case (directed_rows[r].kind)
                ROW_TEXT:  queue_text(directed_rows[r].want);
                ROW_MODEL: format_item(directed_rows[r].item);
                default:   ;
            endcase
        end

        // Phase order: free-running (with the long sink hold), sender gaps, sink stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_off_req   = 1'b1;
                end
                1:
                begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            counted = 0;
            while (counted < RANDOM_PER_PHASE)
            begin
                it = rand_item();
                send_item(it);
                format_item(it);
                if (it.op <= OP_PTR)
                begin
                    counted++;
                end
            end
        end
        item_if.valid <= 1'b0;

        // Drain, then give the block time to show any stray character
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES)
        begin
            @(posedge clk);
        end

        $display("Covered %0d items (%0d with unused kind codes) and %0d characters, %0d of them",
                 items_accepted, items_ignored, chars_checked, empty_strings);
        $display("empty strings, across all six kinds and four idling mixes plus a long sink hold");
        if (error_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

    // Character sink: check every transaction, then decide ready for the next edge
    initial
    begin : char_sink
        char_beat_t want;
        int         hold_left;
        hold_left = 0;
        chars_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (chars_if.valid && chars_if.ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character code 0x%02h last %0b empty %0b",
                                              chars_if.char_code, chars_if.last_char,
                                              chars_if.empty_string));
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (chars_if.char_code !== want.char_code
                        || chars_if.last_char !== want.last_char
                        || chars_if.empty_string !== want.empty_string)
                    begin
                        report_mismatch($sformatf(
                            "char %0d: got 0x%02h/%0b/%0b, want 0x%02h/%0b/%0b (code/last/empty)",
                            chars_checked, chars_if.char_code, chars_if.last_char,
                            chars_if.empty_string, want.char_code, want.last_char,
                            want.empty_string));
                    end
                    if (want.empty_string)
                    begin
                        empty_strings++;
                    end
                    chars_checked++;
                end
            end
            // Long hold: the block fills up and must stall its item input
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chars_if.ready <= 1'b0;
            end
            else
            begin
                chars_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when nothing has moved on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (chars_if.valid && chars_if.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timeout: no transaction for %0d cycles, %0d characters still owed",
                 QUIET_LIMIT, pending_chars.size());
        $display("tb failed");
        $finish;
    end

endmodule

[integer_to_ascii_formatter_unit.f]
src/itoa_pkg.sv
src/itoa_if.sv
src/itoa_ctrl.sv
src/itoa_dpath.sv
src/integer_to_ascii_formatter_unit.sv
src/itoa_checker.sv
tb/tb.sv
